// ===== rtl/core/f2s_pkg.sv =====
// Package with shared types and constants for the double-to-single converter.
`timescale 1ns / 1ps
package f2s_pkg;
	localparam int unsigned DBL_W = 64;
	localparam int unsigned SGL_W = 32;
	localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
	localparam logic [30:0] SGL_INF_MAG = 31'h7F800000;
	localparam logic [30:0] SGL_QNAN_MAG = 31'h7FC00000;
	localparam logic [11:0] EXP_BIAS_DIFF = 12'd896;

	typedef struct packed {
		logic [DBL_W-1:0] double_bits;
		logic is_last;
	} in_beat_t;

	typedef struct packed {
		logic [SGL_W-1:0] single_bits;
		logic last_out;
	} out_beat_t;
endpackage

// ===== rtl/core/f2s_stream_if.sv =====
// Valid/ready stream interface carrying one beat of payload.
`timescale 1ns / 1ps
interface f2s_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/f2s_round.sv =====
// Combinational binary64 to binary32 conversion with round to nearest even.
`timescale 1ns / 1ps
module f2s_round (
	input logic [f2s_pkg::DBL_W-1:0] double_bits,
	output logic [f2s_pkg::SGL_W-1:0] single_bits
);
	import f2s_pkg::*;

	logic sign;
	logic [10:0] exp_d;
	logic [51:0] frac;
	logic [11:0] eb;
	logic [31:0] v_norm;
	logic [28:0] rem_norm;
	logic up_norm;
	logic [5:0] shift;
	logic [52:0] mant;
	logic [113:0] ext;
	logic [23:0] q_sub;
	logic up_sub;

	always_comb begin
		sign = double_bits[63];
		exp_d = double_bits[62:52];
		frac = double_bits[51:0];
		eb = {1'b0, exp_d} - EXP_BIAS_DIFF;
		v_norm = {1'b0, eb[7:0], frac[51:29]};
		rem_norm = frac[28:0];
		up_norm = rem_norm[28] && ((|rem_norm[27:0]) || v_norm[0]);
		v_norm = v_norm + {31'd0, up_norm};
		mant = {1'b1, frac};
		shift = 6'(12'd30 - eb);
		ext = {mant, 61'd0} >> shift;
		q_sub = ext[84:61];
		up_sub = ext[60] && ((|ext[59:0]) || q_sub[0]);
		single_bits = {sign, 31'd0};
		if (exp_d == DBL_EXP_MAX) begin
			if (frac == '0)
				single_bits = {sign, SGL_INF_MAG};
			else
				single_bits = {sign, SGL_QNAN_MAG | {9'd0, frac[50:29]}};
		end else if (exp_d == '0) begin
			single_bits = {sign, 31'd0};
		end else if (!eb[11] && eb >= 12'd255) begin
			single_bits = {sign, SGL_INF_MAG};
		end else if (!eb[11] && eb != '0) begin
			if (v_norm[30:0] >= SGL_INF_MAG)
				single_bits = {sign, SGL_INF_MAG};
			else
				single_bits = {sign, v_norm[30:0]};
		end else if (eb[11] && eb < 12'hFE2) begin
			single_bits = {sign, 31'd0};
		end else begin
			single_bits = {sign, 7'd0, q_sub + {23'd0, up_sub}};
		end
	end

	logic unused_ext;
	assign unused_ext = |ext[113:85];
endmodule

// ===== rtl/core/fp64_to_fp32_converter.sv =====
// Top level of the streaming double-to-single converter.
// Channel | Dir | Payload
// in_s    | in  | double_bits[63:0], is_last
// out_s   | out | single_bits[31:0], last_out
// One beat is accepted per cycle into the input register unless back-pressure
// from out_s holds it; the rounding logic between it and the output register
// is combinational and feeds the output register. Each register advances
// whenever the register after it is empty or being drained. Reset clears only
// the valid flags.
`timescale 1ns / 1ps
module fp64_to_fp32_converter (
	input logic clk,
	input logic arst_n,
	f2s_stream_if.sink in_s,
	f2s_stream_if.source out_s
);
	import f2s_pkg::*;

	logic valid_s1;
	in_beat_t beat_s1;
	logic valid_q;
	out_beat_t res_q;
	logic [SGL_W-1:0] conv;
	in_beat_t in_beat;
	logic res_free;

	assign in_beat = in_s.payload;
	assign res_free = !valid_q || out_s.ready;
	assign in_s.ready = !valid_s1 || res_free;
	assign out_s.valid = valid_q;
	assign out_s.payload = res_q;

	f2s_round u_round (.double_bits(beat_s1.double_bits), .single_bits(conv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (in_s.ready) begin
				valid_s1 <= in_s.valid;
			end
			if (res_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_s.ready && in_s.valid) begin
			beat_s1 <= in_beat;
		end
		if (res_free && valid_s1) begin
			res_q.single_bits <= conv;
			res_q.last_out <= beat_s1.is_last;
		end
	end
endmodule
